// ===== hdl/avm_pkg.sv =====
package avm_pkg;

  // request codes on req_type_i
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_BYTE   = 2'd1,
    REQ_TICK   = 2'd2
  } avm_req_e;

  // commands passed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_READING   = 2'd0,
    CMD_REPLY_MAX = 2'd1,
    CMD_REPLY_MIN = 2'd2,
    CMD_TICK      = 2'd3
  } avm_cmd_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_MEAN  = 2'd1,
    ST_SCALE = 2'd2
  } avm_state_e;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] tx_char;
    logic       last;
    logic [6:0] segments;
    logic       high_digit_on;
  } avm_res_t;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [6:0] FS_RESET   = 7'd33;
  localparam logic [6:0] MAX_TENTHS = 7'd99;

  localparam logic [7:0] BCD_ZERO = 8'h00;
  localparam logic [7:0] BCD_TOP  = 8'h99;

  localparam logic       KIND_SERIAL  = 1'b0;
  localparam logic       KIND_DISPLAY = 1'b1;

  localparam logic [7:0] CHAR_UPPER_M = 8'h4D;
  localparam logic [7:0] CHAR_LOWER_M = 8'h6D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_VOLT    = 8'h56;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // reply is "d.dV\n"
  localparam logic [2:0] REPLY_FIRST_DIGIT = 3'd0;
  localparam logic [2:0] REPLY_DOT         = 3'd1;
  localparam logic [2:0] REPLY_LOW_DIGIT   = 3'd2;
  localparam logic [2:0] REPLY_VOLT        = 3'd3;
  localparam logic [2:0] REPLY_LAST        = 3'd4;

  // seven-segment pattern, bit0 is segment a
  function automatic logic [6:0] seg7(logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'h0:    pat = 7'h3F;
      4'h1:    pat = 7'h06;
      4'h2:    pat = 7'h5B;
      4'h3:    pat = 7'h4F;
      4'h4:    pat = 7'h66;
      4'h5:    pat = 7'h6D;
      4'h6:    pat = 7'h7D;
      4'h7:    pat = 7'h07;
      4'h8:    pat = 7'h7F;
      4'h9:    pat = 7'h6F;
      4'hA:    pat = 7'h77;
      4'hB:    pat = 7'h7C;
      4'hC:    pat = 7'h39;
      4'hD:    pat = 7'h5E;
      4'hE:    pat = 7'h79;
      default: pat = 7'h71;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/averaging_voltmeter_min_max.sv =====
// Averaging voltmeter with min/max report and a two-digit multiplexed display.
// Requests enter on push/full and are taken one per cycle while the four-entry
// command queue has room. ADC samples are summed in the front end at full rate;
// every SAMPLES_PER_READING-th sample queues a reading, which the back end turns
// into tenths of a volt in a three-stage constant-divider pipeline: the mean by
// reciprocal multiplication, then mean * full scale + half, then the division by
// 2^ADC_BITS - 1 as (x + (x >> ADC_BITS) + 1) >> ADC_BITS, saturated to 9.9 V.
// ST_SCALE then splits it into BCD and updates the running min and max. An 'M' or
// 'm' byte yields the five characters "d.dV\n" of the max or min, one per cycle
// while the output is free; a display tick yields one seven-segment update, tens
// digit first. Results leave through a one-entry output register on empty/pop, so
// with pop held the sustained rate is one result per cycle, while a pending reading
// holds later queued requests until it is stored. Samples, unknown bytes and request
// type 3 produce no result. The full-scale register has its own valid/ready channel,
// always ready; the user must write it only while idle, unchecked by the block.
module averaging_voltmeter_min_max #(
  parameter int unsigned SAMPLES_PER_READING = 8,
  parameter int unsigned ADC_BITS            = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type_i,
  input  logic [ADC_BITS-1:0] sample_i,
  input  logic [7:0]          rx_byte_i,
  // full-scale register write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_full_scale_tenths_i,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic                result_kind_o,
  output logic [7:0]          tx_char_o,
  output logic                last_o,
  output logic [6:0]          segments_o,
  output logic                high_digit_on_o
);

  localparam int unsigned SW      = ADC_BITS + $clog2(SAMPLES_PER_READING);
  localparam int unsigned ENTRY_W = avm_pkg::CMD_W + SW;

  logic [6:0]         fs_q;
  logic               accept;
  logic               cmd_push;
  avm_pkg::avm_cmd_e  cmd_kind;
  logic [SW-1:0]      cmd_sum;
  logic [ENTRY_W-1:0] head;
  logic               head_valid, head_pop;
  logic               out_valid;
  avm_pkg::avm_res_t  out_res;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= avm_pkg::FS_RESET;
    end else if (cfg_valid_i) begin
      fs_q <= cfg_full_scale_tenths_i;
    end
  end

  // front end: accumulate samples, decode commands
  avm_front #(
    .ADC_BITS            (ADC_BITS),
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (req_type_i),
    .sample_i   (sample_i),
    .rx_byte_i  (rx_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_kind_o (cmd_kind),
    .cmd_sum_o  (cmd_sum)
  );

  // command queue decouples the front end from the back end
  avm_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  ({cmd_kind, cmd_sum}),
    .full_o  (full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head)
  );

  // back end: reading arithmetic, replies, display
  avm_back #(
    .ADC_BITS            (ADC_BITS),
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fs_i         (fs_q),
    .head_valid_i (head_valid),
    .head_kind_i  (avm_pkg::avm_cmd_e'(head[ENTRY_W-1 -: avm_pkg::CMD_W])),
    .head_sum_i   (head[SW-1:0]),
    .head_pop_o   (head_pop),
    .out_valid_o  (out_valid),
    .out_res_o    (out_res),
    .out_pop_i    (pop)
  );

  assign empty           = !out_valid;
  assign result_kind_o   = out_res.result_kind;
  assign tx_char_o       = out_res.tx_char;
  assign last_o          = out_res.last;
  assign segments_o      = out_res.segments;
  assign high_digit_on_o = out_res.high_digit_on;

endmodule

// ===== hdl/avm_front.sv =====
module avm_front #(
  parameter int unsigned ADC_BITS            = 10,
  parameter int unsigned SAMPLES_PER_READING = 8
) (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   accept_i,
  input  logic [1:0]                                             req_type_i,
  input  logic [ADC_BITS-1:0]                                    sample_i,
  input  logic [7:0]                                             rx_byte_i,
  output logic                                                   cmd_push_o,
  output avm_pkg::avm_cmd_e                                      cmd_kind_o,
  output logic [ADC_BITS+$clog2(SAMPLES_PER_READING)-1:0]        cmd_sum_o
);

  localparam int unsigned SW = ADC_BITS + $clog2(SAMPLES_PER_READING);
  localparam int unsigned CW = $clog2(SAMPLES_PER_READING);

  logic [SW-1:0] sum_q, sum_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sum_next;
  logic          group_end;

  assign sum_next  = sum_q + SW'(sample_i);
  assign group_end = (cnt_q == CW'(SAMPLES_PER_READING - 1));

  // classify the request into a back-end command
  always_comb begin
    cmd_push_o = 1'b0;
    cmd_kind_o = avm_pkg::CMD_TICK;
    cmd_sum_o  = sum_next;
    case (req_type_i)
      avm_pkg::REQ_SAMPLE: begin
        if (accept_i && group_end) begin
          cmd_push_o = 1'b1;
          cmd_kind_o = avm_pkg::CMD_READING;
        end
      end
      avm_pkg::REQ_BYTE: begin
        if (accept_i && rx_byte_i == avm_pkg::CHAR_UPPER_M) begin
          cmd_push_o = 1'b1;
          cmd_kind_o = avm_pkg::CMD_REPLY_MAX;
        end else if (accept_i && rx_byte_i == avm_pkg::CHAR_LOWER_M) begin
          cmd_push_o = 1'b1;
          cmd_kind_o = avm_pkg::CMD_REPLY_MIN;
        end
      end
      avm_pkg::REQ_TICK: begin
        cmd_push_o = accept_i;
        cmd_kind_o = avm_pkg::CMD_TICK;
      end
      default: ;
    endcase
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept_i && req_type_i == avm_pkg::REQ_SAMPLE) begin
      if (group_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/avm_fifo.sv =====
module avm_fifo #(
  parameter int unsigned WIDTH = 15
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned DEPTH = avm_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + NW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - NW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(DEPTH))
    else $error("command queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");

endmodule

// ===== hdl/avm_div.sv =====
module avm_div #(
  parameter int unsigned ADC_BITS            = 10,
  parameter int unsigned SAMPLES_PER_READING = 8
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            start_i,
  input  logic [ADC_BITS+$clog2(SAMPLES_PER_READING)-1:0] sum_i,
  input  logic [6:0]                                      fs_i,
  output logic                                            busy_o,
  output logic                                            done_o,
  output logic [6:0]                                      tenths_o
);

  localparam int unsigned SW        = ADC_BITS + $clog2(SAMPLES_PER_READING);
  // mean = (sum * RECIP) >> K is exact for every sum below 2^SW
  localparam int unsigned K         = SW + $clog2(SAMPLES_PER_READING);
  localparam int unsigned RW        = 2 * SW + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);
  localparam int unsigned NW        = ADC_BITS + 7;
  localparam int unsigned QW        = NW + 1;
  localparam int unsigned FULL_CODE = (1 << ADC_BITS) - 1;
  localparam int unsigned HALF_CODE = FULL_CODE / 2;

  logic [RW-1:0]       recip_prod;
  logic [NW-1:0]       scaled;
  logic [QW-1:0]       quot_sum;
  logic [7:0]          quot;
  logic [6:0]          tenths_d;
  logic [ADC_BITS-1:0] mean_q;
  logic [NW-1:0]       prod_q;
  logic [6:0]          tenths_q;
  logic                v1_q, v2_q, v3_q;

  // stage 1: mean by reciprocal multiplication
  assign recip_prod = RW'(sum_i) * RW'(RECIP);
  // stage 2: mean * full scale + half
  assign scaled     = NW'(mean_q) * NW'(fs_i) + NW'(HALF_CODE);
  // stage 3: x / (2^ADC_BITS - 1) = (x + (x >> ADC_BITS) + 1) >> ADC_BITS in range
  assign quot_sum   = QW'(prod_q) + QW'(prod_q >> ADC_BITS) + QW'(1);
  assign quot       = quot_sum[ADC_BITS +: 8];
  assign tenths_d   = (quot > {1'b0, avm_pkg::MAX_TENTHS}) ? avm_pkg::MAX_TENTHS
                                                            : quot[6:0];

  assign busy_o   = v1_q || v2_q;
  assign done_o   = v3_q;
  assign tenths_o = tenths_q;

  always_ff @(posedge clk_i) begin
    if (start_i) mean_q <= recip_prod[K +: ADC_BITS];
    if (v1_q) prod_q <= scaled;
    if (v2_q) tenths_q <= tenths_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

endmodule

// ===== hdl/avm_back.sv =====
module avm_back #(
  parameter int unsigned ADC_BITS            = 10,
  parameter int unsigned SAMPLES_PER_READING = 8
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic [6:0]                                      fs_i,
  input  logic                                            head_valid_i,
  input  avm_pkg::avm_cmd_e                               head_kind_i,
  input  logic [ADC_BITS+$clog2(SAMPLES_PER_READING)-1:0] head_sum_i,
  output logic                                            head_pop_o,
  output logic                                            out_valid_o,
  output avm_pkg::avm_res_t                               out_res_o,
  input  logic                                            out_pop_i
);

  // tens = (v * 205) >> 11 is exact for v below 1029
  localparam logic [14:0] TENS_MUL   = 15'd205;
  localparam int unsigned TENS_SHIFT = 11;

  avm_pkg::avm_state_e state_q, state_d;
  logic [2:0]        idx_q;
  logic [7:0]        volt_q, min_q, max_q;
  logic              low_next_q;
  logic              out_valid_q;
  avm_pkg::avm_res_t out_q;

  logic              out_free;
  logic              emit, reply_emit, tick_emit, reading_done;
  avm_pkg::avm_res_t res;
  logic              div_start, div_busy, div_done;
  logic [6:0]        div_tenths;
  logic [7:0]        reply_val;
  logic [3:0]        disp_digit;
  logic [6:0]        v_tenths;
  logic [14:0]       tens_prod;
  logic [3:0]        tens;
  logic [6:0]        ones_full;
  logic [7:0]        new_bcd;

  avm_div #(
    .ADC_BITS            (ADC_BITS),
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .sum_i    (head_sum_i),
    .fs_i     (fs_i),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .tenths_o (div_tenths)
  );

  assign out_free    = !out_valid_q || out_pop_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  assign reply_val  = (head_kind_i == avm_pkg::CMD_REPLY_MAX) ? max_q : min_q;
  assign disp_digit = low_next_q ? volt_q[3:0] : volt_q[7:4];

  // split the saturated reading into BCD
  assign v_tenths  = div_tenths;
  assign tens_prod = 15'(v_tenths) * TENS_MUL;
  assign tens      = tens_prod[TENS_SHIFT+3:TENS_SHIFT];
  assign ones_full = v_tenths - 7'(tens) * 7'd10;
  assign new_bcd   = {tens, ones_full[3:0]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      avm_pkg::ST_RUN: begin
        if (head_valid_i && head_kind_i == avm_pkg::CMD_READING) state_d = avm_pkg::ST_MEAN;
      end
      avm_pkg::ST_MEAN: begin
        if (div_done) state_d = avm_pkg::ST_SCALE;
      end
      avm_pkg::ST_SCALE: begin
        state_d = avm_pkg::ST_RUN;
      end
      default: state_d = avm_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    head_pop_o   = 1'b0;
    emit         = 1'b0;
    reply_emit   = 1'b0;
    tick_emit    = 1'b0;
    reading_done = 1'b0;
    div_start    = 1'b0;
    res          = '0;
    unique case (state_q)
      avm_pkg::ST_RUN: begin
        if (head_valid_i) begin
          unique case (head_kind_i) inside
            avm_pkg::CMD_READING: begin
              head_pop_o = 1'b1;
              div_start  = 1'b1;
            end
            avm_pkg::CMD_REPLY_MAX, avm_pkg::CMD_REPLY_MIN: begin
              res.result_kind = avm_pkg::KIND_SERIAL;
              unique case (idx_q)
                avm_pkg::REPLY_FIRST_DIGIT:
                  res.tx_char = avm_pkg::CHAR_ZERO + {4'd0, reply_val[7:4]};
                avm_pkg::REPLY_DOT:
                  res.tx_char = avm_pkg::CHAR_DOT;
                avm_pkg::REPLY_LOW_DIGIT:
                  res.tx_char = avm_pkg::CHAR_ZERO + {4'd0, reply_val[3:0]};
                avm_pkg::REPLY_VOLT:
                  res.tx_char = avm_pkg::CHAR_VOLT;
                default: begin
                  res.tx_char = avm_pkg::CHAR_NEWLINE;
                  res.last    = 1'b1;
                end
              endcase
              if (out_free) begin
                emit       = 1'b1;
                reply_emit = 1'b1;
                head_pop_o = (idx_q == avm_pkg::REPLY_LAST);
              end
            end
            default: begin
              res.result_kind   = avm_pkg::KIND_DISPLAY;
              res.last          = 1'b1;
              res.segments      = avm_pkg::seg7(disp_digit);
              res.high_digit_on = !low_next_q;
              if (out_free) begin
                emit       = 1'b1;
                tick_emit  = 1'b1;
                head_pop_o = 1'b1;
              end
            end
          endcase
        end
      end
      avm_pkg::ST_MEAN: ;
      avm_pkg::ST_SCALE: begin
        reading_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= avm_pkg::ST_RUN;
      idx_q       <= avm_pkg::REPLY_FIRST_DIGIT;
      volt_q      <= avm_pkg::BCD_ZERO;
      min_q       <= avm_pkg::BCD_TOP;
      max_q       <= avm_pkg::BCD_ZERO;
      low_next_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (reply_emit) begin
        idx_q <= (idx_q == avm_pkg::REPLY_LAST) ? avm_pkg::REPLY_FIRST_DIGIT
                                                 : idx_q + 3'd1;
      end
      if (tick_emit) low_next_q <= !low_next_q;
      if (reading_done) begin
        volt_q <= new_bcd;
        if (new_bcd < min_q) min_q <= new_bcd;
        if (new_bcd > max_q) max_q <= new_bcd;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= res;
  end

  a_volt_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (volt_q[3:0] <= 4'd9) && (volt_q[7:4] <= 4'd9))
    else $error("reading is not BCD");

  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == avm_pkg::ST_MEAN) |-> (div_busy || div_done))
    else $error("reading sequencer waits on an idle divider");

  a_reply_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != avm_pkg::REPLY_FIRST_DIGIT) |->
      (head_valid_i && (head_kind_i == avm_pkg::CMD_REPLY_MAX ||
                        head_kind_i == avm_pkg::CMD_REPLY_MIN)))
    else $error("reply in progress without a reply request at the queue head");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import avm_pkg::*;

  // Request type with no meaning to the block: it must be dropped silently.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int unsigned SAMPLES_PER_READING = 8;
  localparam int unsigned ADC_FULL = 1023;
  localparam int unsigned ADC_HALF = 511;

  // Seven-segment patterns for 0..F, digit 0 in the low seven bits, bit0 is segment a.
  localparam logic [16*7-1:0] SEG_ROM = {
    7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
    7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  // Idle time after the last reply before the block counts as idle. A reading holds
  // the back end until it is stored; up to four may sit in the command queue behind it.
  localparam int SETTLE_CYCLES = 250;
  // Long result-side stall that backs the block up and holds off requests.
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AFTER_REQUESTS = 40;
  localparam int RANDOM_PER_PHASE = 33;

  typedef struct {
    logic [1:0] req;
    logic [9:0] smp;
    logic [7:0] ch;
  } meter_req_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] req_type_i = REQ_SAMPLE;
  logic [9:0] sample_i = '0;
  logic [7:0] rx_byte_i = '0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_full_scale_tenths_i = FS_RESET;
  logic       empty;
  logic       pop = 1'b0;
  logic       result_kind_o;
  logic [7:0] tx_char_o;
  logic       last_o;
  logic [6:0] segments_o;
  logic       high_digit_on_o;

  averaging_voltmeter_min_max dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .push                   (push),
    .full                   (full),
    .req_type_i             (req_type_i),
    .sample_i               (sample_i),
    .rx_byte_i              (rx_byte_i),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_full_scale_tenths_i(cfg_full_scale_tenths_i),
    .empty                  (empty),
    .pop                    (pop),
    .result_kind_o          (result_kind_o),
    .tx_char_o              (tx_char_o),
    .last_o                 (last_o),
    .segments_o             (segments_o),
    .high_digit_on_o        (high_digit_on_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Meter state as the block should hold it, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [6:0]  scale_tenths = FS_RESET;
  logic [12:0] acc_sum = '0;
  int unsigned acc_count = 0;
  logic [7:0]  reading_bcd = BCD_ZERO;
  logic [7:0]  lowest_bcd = BCD_TOP;   // starts at the top so the first reading lowers it
  logic [7:0]  highest_bcd = BCD_ZERO;
  logic        show_units = 1'b0;      // tens digit goes out first

  meter_req_t request_q[$];   // requests not yet taken by the block
  avm_res_t   meter_out_q[$]; // characters and display updates still owed, oldest first

  int  requests_taken = 0;
  int  mismatches = 0;
  bit  req_accepted = 1'b0;
  bit  res_accepted = 1'b0;
  int  send_gap = 0;
  int  take_gap = 0;
  bit  steady_sender = 1'b0;
  bit  steady_receiver = 1'b0;
  bit  hold_results = 1'b0;

  function automatic void advance_meter(logic [1:0] req, logic [9:0] smp, logic [7:0] ch);
    int unsigned mean;
    int unsigned tenths;
    logic [7:0]  shown;
    logic [3:0]  digit;
    case (req)
      REQ_SAMPLE: begin
        acc_sum = acc_sum + 13'(smp);
        acc_count++;
        if (acc_count == SAMPLES_PER_READING) begin
          mean = acc_sum / SAMPLES_PER_READING;
          tenths = (mean * scale_tenths + ADC_HALF) / ADC_FULL;
          // saturate at 9.9 V so both digits stay decimal
          if (tenths > MAX_TENTHS) tenths = MAX_TENTHS;
          reading_bcd = 8'(((tenths / 10) << 4) | (tenths % 10));
          if (reading_bcd < lowest_bcd) lowest_bcd = reading_bcd;
          if (reading_bcd > highest_bcd) highest_bcd = reading_bcd;
          acc_sum = '0;
          acc_count = 0;
        end
      end
      REQ_BYTE: begin
        // only 'M' and 'm' are commands, everything else is dropped
        if (ch == CHAR_UPPER_M || ch == CHAR_LOWER_M) begin
          shown = (ch == CHAR_UPPER_M) ? highest_bcd : lowest_bcd;
          meter_out_q.push_back('{KIND_SERIAL, CHAR_ZERO + shown[7:4], 1'b0, 7'd0, 1'b0});
          meter_out_q.push_back('{KIND_SERIAL, CHAR_DOT, 1'b0, 7'd0, 1'b0});
          meter_out_q.push_back('{KIND_SERIAL, CHAR_ZERO + shown[3:0], 1'b0, 7'd0, 1'b0});
          meter_out_q.push_back('{KIND_SERIAL, CHAR_VOLT, 1'b0, 7'd0, 1'b0});
          meter_out_q.push_back('{KIND_SERIAL, CHAR_NEWLINE, 1'b1, 7'd0, 1'b0});
        end
      end
      REQ_TICK: begin
        digit = show_units ? reading_bcd[3:0] : reading_bcd[7:4];
        meter_out_q.push_back('{KIND_DISPLAY, 8'h00, 1'b1, SEG_ROM[digit*7 +: 7],
                                !show_units});
        show_units = !show_units;
      end
      default: ;
    endcase
  endfunction

  // Idle length before the next request or pop: mostly none or short, now and then long.
  function automatic int next_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. The monitor half runs at the rising edge and feeds the meter
  // state; the driver half moves the bus at the falling edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    req_accepted = rst_ni && push && !full;
    if (req_accepted) begin
      advance_meter(req_type_i, sample_i, rx_byte_i);
      requests_taken++;
    end
  end

  always @(negedge clk_i) begin
    if (req_accepted) begin
      void'(request_q.pop_front());
      send_gap = next_gap(steady_sender);
    end
    if (send_gap > 0) begin
      send_gap--;
      push <= 1'b0;
    end else if (rst_ni && request_q.size() != 0) begin
      // a stalled request stays on the bus unchanged until full drops
      push       <= 1'b1;
      req_type_i <= request_q[0].req;
      sample_i   <= request_q[0].smp;
      rx_byte_i  <= request_q[0].ch;
    end else begin
      push <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: every popped result is checked against the oldest one owed.
  // ---------------------------------------------------------------------------
  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    avm_res_t want;
    res_accepted = rst_ni && pop && !empty;
    if (res_accepted) begin
      if (meter_out_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got kind %b char %h seg %h",
                 $time, result_kind_o, tx_char_o, segments_o);
      end else begin
        want = meter_out_q.pop_front();
        check_field("result_kind", 8'(want.result_kind), 8'(result_kind_o));
        check_field("tx_char", want.tx_char, tx_char_o);
        check_field("last", 8'(want.last), 8'(last_o));
        check_field("segments", 8'(want.segments), 8'(segments_o));
        check_field("high_digit_on", 8'(want.high_digit_on), 8'(high_digit_on_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (res_accepted) take_gap = next_gap(steady_receiver);
    if (hold_results) begin
      pop <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni;
    end
  end

  // One long result-side stall while requests keep coming, so the command queue
  // fills and full has to hold the sender off.
  initial begin
    while (requests_taken < HOLD_AFTER_REQUESTS) @(posedge clk_i);
    hold_results = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_results = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_request(logic [1:0] req, logic [9:0] smp, logic [7:0] ch);
    request_q.push_back('{req, smp, ch});
  endtask

  // Wait until every request is in and every owed result is out, then let any
  // reading still in the divider finish.
  task automatic drain();
    while (request_q.size() != 0 || meter_out_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The register may only change while the block is idle; the channel is always ready.
  task automatic write_full_scale(logic [6:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_full_scale_tenths_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    scale_tenths = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly complete readings of eight samples near one level, so readings sweep
  // the whole scale (saturation included); the rest is loose samples, commands,
  // noise bytes, ticks and unused request types.
  task automatic queue_random_requests(int n);
    int added;
    int r;
    int level;
    int v;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        level = $urandom_range(0, 1023);
        for (int k = 0; k < SAMPLES_PER_READING; k++) begin
          v = level + $urandom_range(0, 15);
          if (v > 1023) v = 1023;
          add_request(REQ_SAMPLE, 10'(v), 8'($urandom_range(0, 255)));
        end
        added += SAMPLES_PER_READING;
      end else begin
        if (r < 52)
          add_request(REQ_SAMPLE, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
        else if (r < 64)
          add_request(REQ_BYTE, 10'($urandom_range(0, 1023)),
                      $urandom_range(0, 1) ? CHAR_UPPER_M : CHAR_LOWER_M);
        else if (r < 70)
          add_request(REQ_BYTE, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
        else if (r < 94)
          add_request(REQ_TICK, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
        else
          add_request(REQ_UNUSED, 10'($urandom_range(0, 1023)),
                      8'($urandom_range(0, 255)));
        added++;
      end
    end
  endtask

  // Full-scale settings for the random phases: both ends of the field, zero,
  // the documented range ends, a random value and back to the reset value.
  logic [6:0] scale_plan[6];

  initial begin
    scale_plan = '{7'd127, 7'd0, 7'd1, 7'd99, 7'($urandom_range(2, 126)), FS_RESET};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset full scale. Before any reading the minimum still
    // reports its top value and the maximum reports zero.
    add_request(REQ_BYTE, 10'd0, CHAR_LOWER_M);
    add_request(REQ_BYTE, 10'd0, CHAR_UPPER_M);
    add_request(REQ_TICK, 10'd0, 8'd0);
    add_request(REQ_TICK, 10'd0, 8'd0);
    // eight samples at the top code: exactly the full scale, 3.3 V
    repeat (SAMPLES_PER_READING) add_request(REQ_SAMPLE, 10'd1023, 8'd0);
    add_request(REQ_TICK, 10'd0, 8'd0);
    add_request(REQ_BYTE, 10'd0, CHAR_UPPER_M);
    add_request(REQ_BYTE, 10'd0, CHAR_LOWER_M);
    // unused request type and bytes that are no command: nothing comes back
    add_request(REQ_UNUSED, 10'd1023, CHAR_UPPER_M);
    add_request(REQ_BYTE, 10'd0, 8'hFF);
    add_request(REQ_BYTE, 10'd0, 8'h00);
    // a reading whose truncated mean is zero
    repeat (SAMPLES_PER_READING / 2) begin
      add_request(REQ_SAMPLE, 10'd0, 8'd0);
      add_request(REQ_SAMPLE, 10'd1, 8'd0);
    end
    add_request(REQ_BYTE, 10'd0, CHAR_LOWER_M);
    add_request(REQ_TICK, 10'd0, 8'd0);
    drain();

    foreach (scale_plan[i]) begin
      write_full_scale(scale_plan[i]);
      steady_sender = ($urandom_range(0, 3) == 0);
      steady_receiver = ($urandom_range(0, 3) == 0);
      queue_random_requests(RANDOM_PER_PHASE);
      drain();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/avm_pkg.sv
hdl/avm_front.sv
hdl/avm_fifo.sv
hdl/avm_div.sv
hdl/avm_back.sv
hdl/averaging_voltmeter_min_max.sv
sim/testbench.sv
